// ===== design/bsdel_pkg.sv =====
// Shared types and constants for the bounded stack with delete-all.
// Used by bsdel_cell, bsdel_ctrl and bounded_stack_with_delete_all_core.
package bsdel_pkg;

  localparam int CAPACITY = 64;
  localparam int WORD_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DEPTH_W  = 7;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_TOP     = 3'd2,
    OP_POP_TOP = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_PURGE   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    CM_HOLD = 2'd0,
    CM_PUSH = 2'd1,
    CM_POP  = 2'd2,
    CM_ROT  = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [CNT_W-1:0] len;
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] read_data;
    logic [DEPTH_W-1:0]       depth_now;
    logic                     is_empty;
    logic                     is_full;
  } out_item_t;

endpackage

// ===== design/bounded_stack_with_delete_all_core.sv =====
// Push, pop, top, pop_top, clear, unused codes and an empty-stack purge give
// their result in the cycle after the transaction is accepted; one such
// transaction per cycle while no purge is busy. Any other purge walks the row
// once per held entry, busy meanwhile, and its result follows at the end.
// Reset clears the entry count and sequencer; cell contents are not reset.
// The receiver cannot stall: each result is shown for one cycle with out_valid.
module bounded_stack_with_delete_all_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  bsdel_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output bsdel_pkg::out_item_t out_item
);

  bsdel_pkg::cell_cmd_t                cmd;
  logic signed [bsdel_pkg::WORD_W-1:0] cell_q [bsdel_pkg::CAPACITY];

  bsdel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .top_word  (cell_q[0]),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  for (genvar i = 0; i < bsdel_pkg::CAPACITY; i++) begin : g_cell
    logic signed [bsdel_pkg::WORD_W-1:0] prev_d;
    logic signed [bsdel_pkg::WORD_W-1:0] next_d;

    if (i == 0) begin : g_head
      assign prev_d = in_item.value;
    end else begin : g_body
      assign prev_d = cell_q[i-1];
    end

    if (i == bsdel_pkg::CAPACITY - 1) begin : g_tail
      assign next_d = cell_q[i];
    end else begin : g_mid
      assign next_d = cell_q[i+1];
    end

    bsdel_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (bsdel_pkg::CNT_W'(i + 1)),
      .prev_data (prev_d),
      .next_data (next_d),
      .wrap_data (cell_q[0]),
      .data      (cell_q[i])
    );
  end

  // a transaction other than a purge always answers in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.operation != bsdel_pkg::OP_PURGE) |=> out_valid)
    else $error("missing result after single-cycle transaction");

  // no result while the delete walk is running
  assert property (@(posedge clk) disable iff (!rst_n) busy |-> !out_valid)
    else $error("result strobe during delete walk");

  // the end of a delete walk delivers its result
  assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("delete walk ended without a result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.is_empty && out_item.is_full))
    else $error("stack reported empty and full at once");

endmodule

// ===== design/bsdel_cell.sv =====
// One storage cell of the stack row; cell 0 holds the top entry.
// Depends on bsdel_pkg for the command struct and word width.
module bsdel_cell (
  input  logic                               clk,
  input  bsdel_pkg::cell_cmd_t               cmd,
  input  logic [bsdel_pkg::CNT_W-1:0]        pos,
  input  logic signed [bsdel_pkg::WORD_W-1:0] prev_data,
  input  logic signed [bsdel_pkg::WORD_W-1:0] next_data,
  input  logic signed [bsdel_pkg::WORD_W-1:0] wrap_data,
  output logic signed [bsdel_pkg::WORD_W-1:0] data
);

  logic signed [bsdel_pkg::WORD_W-1:0] data_r;
  logic signed [bsdel_pkg::WORD_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd.mode)
      bsdel_pkg::CM_PUSH: data_nxt = prev_data;
      bsdel_pkg::CM_POP:  data_nxt = next_data;
      bsdel_pkg::CM_ROT: begin
        // rotate the live region: advance inside it, take the old top at its end
        if (pos < cmd.len) begin
          data_nxt = next_data;
        end else if (pos == cmd.len) begin
          data_nxt = wrap_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== design/bsdel_ctrl.sv =====
// Sequencer for the stack: entry count, delete-all walk and result register.
// Depends on bsdel_pkg; drives the command broadcast to the bsdel_cell row.
module bsdel_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  bsdel_pkg::in_item_t                 in_item,
  input  logic signed [bsdel_pkg::WORD_W-1:0] top_word,
  output bsdel_pkg::cell_cmd_t                cmd,
  output logic                                out_valid,
  output bsdel_pkg::out_item_t                out_item
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DEL  = 2'b10
  } state_t;

  state_t                              state_r, state_nxt;
  logic [bsdel_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [bsdel_pkg::CNT_W-1:0]         steps_r, steps_nxt;
  logic signed [bsdel_pkg::WORD_W-1:0] val_r, val_nxt;
  logic                                out_valid_r, out_valid_nxt;
  bsdel_pkg::out_item_t                out_item_r;
  logic [1:0]                          status;
  logic signed [bsdel_pkg::WORD_W-1:0] rd;
  logic                                accept;
  logic                                hit;

  assign busy   = (state_r == S_DEL);
  assign accept = start && !busy;
  assign hit    = (top_word == val_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    status        = bsdel_pkg::STAT_OK;
    rd            = '0;
    cmd.mode      = bsdel_pkg::CM_HOLD;
    cmd.len       = count_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (in_item.operation)
            bsdel_pkg::OP_PUSH: begin
              if (count_r == bsdel_pkg::CAP_CNT) begin
                status = bsdel_pkg::STAT_OVERFLOW;
              end else begin
                cmd.mode  = bsdel_pkg::CM_PUSH;
                count_nxt = count_r + bsdel_pkg::CNT_W'(1);
              end
            end
            bsdel_pkg::OP_POP, bsdel_pkg::OP_TOP, bsdel_pkg::OP_POP_TOP: begin
              if (count_r == '0) begin
                status = bsdel_pkg::STAT_UNDERFLOW;
              end else begin
                if (in_item.operation != bsdel_pkg::OP_POP) begin
                  rd = top_word;
                end
                if (in_item.operation != bsdel_pkg::OP_TOP) begin
                  cmd.mode  = bsdel_pkg::CM_POP;
                  count_nxt = count_r - bsdel_pkg::CNT_W'(1);
                end
              end
            end
            bsdel_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            bsdel_pkg::OP_PURGE: begin
              if (count_r != '0) begin
                // walk every entry once; result comes at the end of the walk
                out_valid_nxt = 1'b0;
                state_nxt     = S_DEL;
                steps_nxt     = count_r;
                val_nxt       = in_item.value;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DEL: begin
        // rotate the live region; a matching top drops out of it
        cmd.mode  = bsdel_pkg::CM_ROT;
        count_nxt = count_r - bsdel_pkg::CNT_W'(hit);
        steps_nxt = steps_r - bsdel_pkg::CNT_W'(1);
        if (steps_r == bsdel_pkg::CNT_W'(1)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (out_valid_nxt) begin
      out_item_r.status    <= status;
      out_item_r.read_data <= rd;
      out_item_r.depth_now <= bsdel_pkg::DEPTH_W'(count_nxt);
      out_item_r.is_empty  <= (count_nxt == '0);
      out_item_r.is_full   <= (count_nxt == bsdel_pkg::CAP_CNT);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
